FILE: sv/smt_pkg.sv
// Shared constants, register codes and types for the spatial motion transform unit.
`default_nettype none

package smt_pkg;

    // Vector component format (Q16.16) and rotation entry format (Q2.14).
    localparam int DATA_WIDTH    = 32;
    localparam int DATA_FRAC     = 16;
    localparam int ROT_FRAC_BITS = 14;
    localparam int ROT_ENTRY_W   = 16;
    localparam int ROW_W         = 3 * ROT_ENTRY_W;
    localparam int VEC_N         = 3;

    // Stream payload: six components, angular first, x in the lowest bits.
    localparam int TDATA_W = 2 * VEC_N * DATA_WIDTH;

    // Internal precision of the linear path and the shifts that align its terms.
    localparam int LIN_FRAC  = (2 * DATA_FRAC > ROT_FRAC_BITS + DATA_FRAC) ?
                               2 * DATA_FRAC : ROT_FRAC_BITS + DATA_FRAC;
    localparam int RL_SHIFT  = LIN_FRAC - (ROT_FRAC_BITS + DATA_FRAC);
    localparam int CX_SHIFT  = LIN_FRAC - 2 * DATA_FRAC;
    localparam int LIN_ROUND = LIN_FRAC - DATA_FRAC;

    // Product and sum widths.
    localparam int PROD_W  = ROT_ENTRY_W + DATA_WIDTH;
    localparam int DOT_W   = PROD_W + 2;
    localparam int CROSS_W = 2 * DATA_WIDTH;
    localparam int WIDE_W  = CROSS_W + 2 + LIN_FRAC;
    localparam int SAT_W   = WIDE_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z  = 3'd5;

    // Reset values: identity rotation, zero translation.
    localparam logic [ROW_W-1:0] ROT_ONE = ROW_W'(1) << ROT_FRAC_BITS;
    localparam logic [ROW_W-1:0] ROW0_RESET = ROT_ONE;
    localparam logic [ROW_W-1:0] ROW1_RESET = ROT_ONE << ROT_ENTRY_W;
    localparam logic [ROW_W-1:0] ROW2_RESET = ROT_ONE << (2 * ROT_ENTRY_W);

    typedef logic signed [DATA_WIDTH-1:0]  data_t;
    typedef logic signed [ROT_ENTRY_W-1:0] rot_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [DOT_W-1:0]       dot_t;
    typedef logic signed [CROSS_W-1:0]     cross_t;

endpackage

`default_nettype wire

FILE: sv/spatial_motion_transform_unit.sv
// Pipelined transform of spatial motion vectors by a configured rotation and translation.
// An input transfer passes through the product, row-sum and cross-term registers into the output register.
// Throughput: one vector per cycle while the output accepts; the four stages each hold one vector with a valid bit.
// A stage advances whenever it is empty or the stage after it advances, so stalls hold data.
// Reset clears all valid bits, loads the identity rotation and a zero translation.
`default_nettype none

module spatial_motion_transform_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration write port.
    input  wire logic                                cfg_we,
    input  wire logic [smt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [smt_pkg::ROW_W-1:0]           cfg_data,
    // Input stream.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata from bit 0: ang_x, ang_y, ang_z, lin_x, lin_y, lin_z (32 bits each).
    input  wire logic [smt_pkg::TDATA_W-1:0]         s_axis_tdata,
    // tlast: batch_end.
    input  wire logic                                s_axis_tlast,
    // Output stream.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata from bit 0: out_ang_x, out_ang_y, out_ang_z, out_lin_x, out_lin_y, out_lin_z.
    output logic [smt_pkg::TDATA_W-1:0]              m_axis_tdata,
    // tlast: out_batch_end.
    output logic                                     m_axis_tlast
);

    localparam int DW = smt_pkg::DATA_WIDTH;
    localparam int N  = smt_pkg::VEC_N;
    localparam int EW = smt_pkg::ROT_ENTRY_W;

    // Clamp a wide signed value to the signed data range.
    function automatic smt_pkg::data_t sat_data(input logic signed [smt_pkg::SAT_W-1:0] v);
        logic all_zero;
        logic all_one;
        all_zero = (v[smt_pkg::SAT_W-1:DW-1] == '0);
        all_one  = (v[smt_pkg::SAT_W-1:DW-1] == '1);
        if (all_zero || all_one)
            sat_data = v[DW-1:0];
        else if (v[smt_pkg::SAT_W-1])
            sat_data = {1'b1, {(DW-1){1'b0}}};
        else
            sat_data = {1'b0, {(DW-1){1'b1}}};
    endfunction

    // Configuration registers.
    logic [smt_pkg::ROW_W-1:0] rot_row_reg [N];
    smt_pkg::data_t            trans_reg   [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_row_reg[0] <= smt_pkg::ROW0_RESET;
            rot_row_reg[1] <= smt_pkg::ROW1_RESET;
            rot_row_reg[2] <= smt_pkg::ROW2_RESET;
            trans_reg[0]   <= '0;
            trans_reg[1]   <= '0;
            trans_reg[2]   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                smt_pkg::REG_ROT_ROW0: rot_row_reg[0] <= cfg_data;
                smt_pkg::REG_ROT_ROW1: rot_row_reg[1] <= cfg_data;
                smt_pkg::REG_ROT_ROW2: rot_row_reg[2] <= cfg_data;
                smt_pkg::REG_TRANS_X:  trans_reg[0]   <= cfg_data[DW-1:0];
                smt_pkg::REG_TRANS_Y:  trans_reg[1]   <= cfg_data[DW-1:0];
                smt_pkg::REG_TRANS_Z:  trans_reg[2]   <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // Stage handshake: each stage takes new data when empty or when it hands its own on.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !v4_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Unpack the input components and the rotation entries.
    smt_pkg::data_t va [N];
    smt_pkg::data_t vl [N];
    smt_pkg::rot_t  rot [N][N];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            va[i] = s_axis_tdata[i*DW +: DW];
            vl[i] = s_axis_tdata[(N+i)*DW +: DW];
            for (int c = 0; c < N; c++)
                rot[i][c] = rot_row_reg[i][c*EW +: EW];
        end
    end

    // Stage 1: the eighteen rotation products.
    smt_pkg::prod_t pa_reg [N][N];
    smt_pkg::prod_t pl_reg [N][N];
    logic           last1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
        begin
            for (int r = 0; r < N; r++)
                for (int c = 0; c < N; c++)
                begin
                    pa_reg[r][c] <= rot[r][c] * va[c];
                    pl_reg[r][c] <= rot[r][c] * vl[c];
                end
            last1_reg <= s_axis_tlast;
        end
    end

    // Stage 2: row sums; the angular sums are rounded and saturated here.
    smt_pkg::dot_t  dot_a [N];
    smt_pkg::dot_t  dot_l [N];
    smt_pkg::data_t wa_next [N];

    always_comb
    begin
        for (int r = 0; r < N; r++)
        begin
            dot_a[r] = smt_pkg::DOT_W'(pa_reg[r][0]) + smt_pkg::DOT_W'(pa_reg[r][1])
                     + smt_pkg::DOT_W'(pa_reg[r][2])
                     + (smt_pkg::DOT_W'(1) << (smt_pkg::ROT_FRAC_BITS - 1));
            dot_l[r] = smt_pkg::DOT_W'(pl_reg[r][0]) + smt_pkg::DOT_W'(pl_reg[r][1])
                     + smt_pkg::DOT_W'(pl_reg[r][2]);
            wa_next[r] = sat_data(smt_pkg::SAT_W'(dot_a[r] >>> smt_pkg::ROT_FRAC_BITS));
        end
    end

    smt_pkg::data_t wa2_reg [N];
    smt_pkg::dot_t  rl2_reg [N];
    logic           last2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            for (int r = 0; r < N; r++)
            begin
                wa2_reg[r] <= wa_next[r];
                rl2_reg[r] <= dot_l[r];
            end
            last2_reg <= last1_reg;
        end
    end

    // Stage 3: the six cross product terms of p x w_ang.
    smt_pkg::cross_t pab_reg [N];
    smt_pkg::cross_t pba_reg [N];
    smt_pkg::data_t  wa3_reg [N];
    smt_pkg::dot_t   rl3_reg [N];
    logic            last3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            for (int i = 0; i < N; i++)
            begin
                pab_reg[i] <= trans_reg[(i+1)%N] * wa2_reg[(i+2)%N];
                pba_reg[i] <= trans_reg[(i+2)%N] * wa2_reg[(i+1)%N];
                wa3_reg[i] <= wa2_reg[i];
                rl3_reg[i] <= rl2_reg[i];
            end
            last3_reg <= last2_reg;
        end
    end

    // Stage 4: align and add the linear terms, round once, saturate.
    logic signed [smt_pkg::WIDE_W-1:0] lin_sum [N];
    smt_pkg::data_t                    wl_next [N];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            lin_sum[i] = (smt_pkg::WIDE_W'(rl3_reg[i]) <<< smt_pkg::RL_SHIFT)
                       + ((smt_pkg::WIDE_W'(pab_reg[i]) - smt_pkg::WIDE_W'(pba_reg[i]))
                          <<< smt_pkg::CX_SHIFT)
                       + (smt_pkg::WIDE_W'(1) << (smt_pkg::LIN_ROUND - 1));
            wl_next[i] = sat_data(smt_pkg::SAT_W'(lin_sum[i] >>> smt_pkg::LIN_ROUND));
        end
    end

    // Output register.
    logic [smt_pkg::TDATA_W-1:0] out_data_reg;
    logic                        out_last_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            for (int i = 0; i < N; i++)
            begin
                out_data_reg[i*DW +: DW]     <= wa3_reg[i];
                out_data_reg[(N+i)*DW +: DW] <= wl_next[i];
            end
            out_last_reg <= last3_reg;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tlast = out_last_reg;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the spatial motion transform unit with stream stimulus.
`timescale 1ns / 100ps

module testbench;

    localparam int VEC_W       = smt_pkg::VEC_N * smt_pkg::DATA_WIDTH;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS  = 1000000;
    localparam int MAX_REPORTS = 10;

    localparam logic [smt_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO =
        smt_pkg::REG_TRANS_Z + smt_pkg::CFG_IDX_W'(1);
    localparam logic [smt_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;

    localparam logic signed [127:0] WIDE_ONE = 128'sd1;
    localparam logic signed [127:0] SAT_HI   =
        (WIDE_ONE <<< (smt_pkg::DATA_WIDTH - 1)) - WIDE_ONE;
    localparam logic signed [127:0] SAT_LO   = -(WIDE_ONE <<< (smt_pkg::DATA_WIDTH - 1));

    localparam logic [smt_pkg::DATA_WIDTH-1:0] Q_MAX =
        {1'b0, {(smt_pkg::DATA_WIDTH - 1){1'b1}}};
    localparam logic [smt_pkg::DATA_WIDTH-1:0] Q_MIN =
        {1'b1, {(smt_pkg::DATA_WIDTH - 1){1'b0}}};

    localparam logic [smt_pkg::ROT_ENTRY_W-1:0] ROT_EDGE [7] = '{16'h7FFF, 16'h8000,
                                                      16'h4000, 16'hC000, 16'h0000,
                                                      16'h0001, 16'hFFFF};
    localparam logic [smt_pkg::DATA_WIDTH-1:0] DATA_EDGE [7] = '{32'h7FFF_FFFF,
                                                      32'h8000_0000,
                                                      32'h0000_0000, 32'hFFFF_FFFF,
                                                      32'h0000_0001, 32'h0001_0000,
                                                      32'hFFFF_0000};

    // One spatial motion vector as it travels on either stream.
    typedef struct packed {
        logic [smt_pkg::VEC_N-1:0][smt_pkg::DATA_WIDTH-1:0] lin;
        logic [smt_pkg::VEC_N-1:0][smt_pkg::DATA_WIDTH-1:0] ang;
        logic                                               last;
    } motion_vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          cfg_we = 1'b0;
    logic [smt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [smt_pkg::ROW_W-1:0]     cfg_data = '0;

    logic                        s_axis_tvalid = 1'b0;
    wire logic                   s_axis_tready;
    logic [smt_pkg::TDATA_W-1:0] s_axis_tdata = '0;
    logic                        s_axis_tlast = 1'b0;

    wire logic                        m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    wire logic [smt_pkg::TDATA_W-1:0] m_axis_tdata;
    wire logic                        m_axis_tlast;

    // Shadow copy of the transform registers.
    logic [smt_pkg::ROW_W-1:0] rot_row [smt_pkg::VEC_N];
    smt_pkg::data_t            trans [smt_pkg::VEC_N];

    motion_vec_t transformed_q [$];
    int          mismatch_count = 0;
    int          stall_left = 0;
    bit          idle_en = 1'b1;
    string       axis_name [smt_pkg::VEC_N] = '{"x", "y", "z"};

    spatial_motion_transform_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock, 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard limit on the run time.
    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    // Exact product of two signed values.
    function automatic logic signed [127:0] wide_mul(input logic signed [127:0] x,
                                                     input logic signed [127:0] y);
        return x * y;
    endfunction

    // Round off sh fraction bits (half up, then floor) and clamp to the data range.
    function automatic smt_pkg::data_t round_sat_q(input logic signed [127:0] acc,
                                                   input int sh);
        logic signed [127:0] r;
        r = (acc + (WIDE_ONE <<< (sh - 1))) >>> sh;
        if (r > SAT_HI)
            return smt_pkg::data_t'(Q_MAX);
        if (r < SAT_LO)
            return smt_pkg::data_t'(Q_MIN);
        return smt_pkg::data_t'(r[smt_pkg::DATA_WIDTH-1:0]);
    endfunction

    // Expected output vector for one input vector under the shadow transform.
    function automatic motion_vec_t transform_vector(input motion_vec_t v);
        motion_vec_t         w;
        logic signed [127:0] acc;
        logic signed [127:0] cx;
        int                  i;
        int                  c;
        int                  a;
        int                  b;
        // Rotated angular part.
        for (i = 0; i < smt_pkg::VEC_N; i++)
        begin
            acc = '0;
            for (c = 0; c < smt_pkg::VEC_N; c++)
                acc = acc + wide_mul(smt_pkg::rot_t'(rot_row[i][smt_pkg::ROT_ENTRY_W*c +:
                                                                 smt_pkg::ROT_ENTRY_W]),
                                     smt_pkg::data_t'(v.ang[c]));
            w.ang[i] = round_sat_q(acc, smt_pkg::ROT_FRAC_BITS);
        end
        // Rotated linear part plus the translation cross term on the rounded angular part.
        for (i = 0; i < smt_pkg::VEC_N; i++)
        begin
            a = (i + 1) % smt_pkg::VEC_N;
            b = (i + 2) % smt_pkg::VEC_N;
            acc = '0;
            for (c = 0; c < smt_pkg::VEC_N; c++)
                acc = acc + wide_mul(smt_pkg::rot_t'(rot_row[i][smt_pkg::ROT_ENTRY_W*c +:
                                                                 smt_pkg::ROT_ENTRY_W]),
                                     smt_pkg::data_t'(v.lin[c]));
            cx = wide_mul(trans[a], smt_pkg::data_t'(w.ang[b]))
               - wide_mul(trans[b], smt_pkg::data_t'(w.ang[a]));
            w.lin[i] = round_sat_q((acc <<< smt_pkg::RL_SHIFT) + (cx <<< smt_pkg::CX_SHIFT),
                                   smt_pkg::LIN_ROUND);
        end
        w.last = v.last;
        return w;
    endfunction

    // Report one wrong field; only the first few are printed.
    task automatic note_mismatch(input string what,
                                 input logic [smt_pkg::DATA_WIDTH-1:0] want,
                                 input logic [smt_pkg::DATA_WIDTH-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %s: expected %h, actual %h", what, want, got);
    endtask

    // Compare one output transfer with the oldest expected vector.
    task automatic check_result(input motion_vec_t got);
        motion_vec_t want;
        int          k;
        if (transformed_q.size() == 0)
        begin
            note_mismatch("unexpected result, out_ang_x", 'x, got.ang[0]);
            return;
        end
        want = transformed_q.pop_front();
        for (k = 0; k < smt_pkg::VEC_N; k++)
        begin
            if (got.ang[k] !== want.ang[k])
                note_mismatch({"out_ang_", axis_name[k]}, want.ang[k], got.ang[k]);
            if (got.lin[k] !== want.lin[k])
                note_mismatch({"out_lin_", axis_name[k]}, want.lin[k], got.lin[k]);
        end
        if (got.last !== want.last)
            note_mismatch("out_batch_end", 32'(want.last), 32'(got.last));
    endtask

    // Output monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result('{lin: m_axis_tdata[2*VEC_W-1:VEC_W], ang: m_axis_tdata[VEC_W-1:0],
                           last: m_axis_tlast});
    end

    // Receiver backpressure in random bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Send one vector and record its expected result once the transfer happens.
    task automatic send_vector(input motion_vec_t v);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {v.lin, v.ang};
        s_axis_tlast <= v.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        transformed_q.push_back(transform_vector(v));
    endtask

    // Stop sending and wait until every expected vector has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (transformed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register and track it in the shadow copy.
    task automatic write_register(input logic [smt_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [smt_pkg::ROW_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            smt_pkg::REG_ROT_ROW0: rot_row[0] = value;
            smt_pkg::REG_ROT_ROW1: rot_row[1] = value;
            smt_pkg::REG_ROT_ROW2: rot_row[2] = value;
            smt_pkg::REG_TRANS_X:  trans[0] = smt_pkg::data_t'(value[smt_pkg::DATA_WIDTH-1:0]);
            smt_pkg::REG_TRANS_Y:  trans[1] = smt_pkg::data_t'(value[smt_pkg::DATA_WIDTH-1:0]);
            smt_pkg::REG_TRANS_Z:  trans[2] = smt_pkg::data_t'(value[smt_pkg::DATA_WIDTH-1:0]);
            default: ;
        endcase
    endtask

    // Load a full transform while the block is idle. Translation writes carry junk in
    // the unused upper bits, and a junk write to an unmapped index follows.
    task automatic load_transform(input logic [smt_pkg::ROW_W-1:0] r0,
                                  input logic [smt_pkg::ROW_W-1:0] r1,
                                  input logic [smt_pkg::ROW_W-1:0] r2,
                                  input logic [smt_pkg::DATA_WIDTH-1:0] px,
                                  input logic [smt_pkg::DATA_WIDTH-1:0] py,
                                  input logic [smt_pkg::DATA_WIDTH-1:0] pz);
        drain_results();
        write_register(smt_pkg::REG_ROT_ROW0, r0);
        write_register(smt_pkg::REG_ROT_ROW1, r1);
        write_register(smt_pkg::REG_ROT_ROW2, r2);
        write_register(smt_pkg::REG_TRANS_X, {16'($urandom), px});
        write_register(smt_pkg::REG_TRANS_Y, {16'($urandom), py});
        write_register(smt_pkg::REG_TRANS_Z, {16'($urandom), pz});
        write_register($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                       smt_pkg::ROW_W'({$urandom, $urandom}));
        cfg_we <= 1'b0;
    endtask

    function automatic motion_vec_t uniform_vector(input logic [smt_pkg::DATA_WIDTH-1:0] value,
                                                   input logic last);
        motion_vec_t v;
        v.ang = {smt_pkg::VEC_N{value}};
        v.lin = {smt_pkg::VEC_N{value}};
        v.last = last;
        return v;
    endfunction

    // Rotation entry: any pattern, a plausible rotation entry, or an edge value.
    function automatic logic [smt_pkg::ROT_ENTRY_W-1:0] rand_rot_entry(input int kind);
        case (kind)
            0:       return 16'($urandom);
            1:       return 16'(int'($urandom_range(0, 32768)) - 16384);
            default: return ROT_EDGE[$urandom_range(0, 6)];
        endcase
    endfunction

    function automatic logic [smt_pkg::ROW_W-1:0] rand_rot_row(input int kind);
        return {rand_rot_entry(kind), rand_rot_entry(kind), rand_rot_entry(kind)};
    endfunction

    // Component: within +/-4.0 with probability bias percent, else full range or an edge.
    function automatic logic [smt_pkg::DATA_WIDTH-1:0] rand_component(input int bias);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < bias)
            return 32'(int'($urandom_range(0, 32'h80000)) - 32'h40000);
        if (pick < 92)
            return $urandom;
        return DATA_EDGE[$urandom_range(0, 6)];
    endfunction

    function automatic motion_vec_t rand_vector(input int bias);
        motion_vec_t v;
        int          k;
        for (k = 0; k < smt_pkg::VEC_N; k++)
        begin
            v.ang[k] = rand_component(bias);
            v.lin[k] = rand_component(bias);
        end
        v.last = ($urandom_range(0, 7) == 0);
        return v;
    endfunction

    // Reset values: identity rotation and zero translation pass vectors through.
    task automatic test_reset_identity();
        send_vector(uniform_vector('0, 1'b0));
        send_vector(uniform_vector(Q_MAX, 1'b1));
        send_vector(uniform_vector(Q_MIN, 1'b0));
        send_vector(uniform_vector('1, 1'b1));
        send_vector('{lin: {32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h0F0F_F0F0},
                      ang: {32'hF0F0_0F0F, 32'h1234_5678, 32'hEDCB_A987}, last: 1'b0});
    endtask

    // Extreme, non-orthogonal rotations and translations drive outputs into saturation,
    // and the cross term works on the clamped angular part.
    task automatic test_saturation();
        load_transform({3{ROT_EDGE[0]}}, {3{ROT_EDGE[0]}}, {3{ROT_EDGE[0]}},
                       Q_MAX, Q_MIN, 32'h1234_5678);
        send_vector(uniform_vector(Q_MAX, 1'b0));
        send_vector(uniform_vector(Q_MIN, 1'b1));
        send_vector('{lin: {Q_MIN, Q_MAX, Q_MIN}, ang: {Q_MAX, Q_MIN, Q_MAX}, last: 1'b0});
        load_transform({3{ROT_EDGE[1]}}, {3{ROT_EDGE[1]}}, {3{ROT_EDGE[1]}},
                       Q_MIN, Q_MAX, '1);
        send_vector(uniform_vector(Q_MIN, 1'b1));
        send_vector(uniform_vector(Q_MAX, 1'b0));
        send_vector('{lin: {Q_MAX, 32'h0001_0000, Q_MIN}, ang: {32'h0000_8000, Q_MIN, Q_MAX},
                      last: 1'b1});
    endtask

    // One-LSB rotation entries put exact halves on both rounding points.
    task automatic test_rounding_ties();
        load_transform(48'h0000_0000_0001, 48'h0000_0001_0000, 48'h0001_0000_0000, '0, '0, '0);
        send_vector(uniform_vector(32'h0000_2000, 1'b0));
        send_vector(uniform_vector(-32'sd8192, 1'b1));
        send_vector(uniform_vector(32'h0000_1FFF, 1'b0));
        send_vector(uniform_vector(32'h0000_6000, 1'b0));
        send_vector(uniform_vector(-32'sd24576, 1'b1));
        load_transform(smt_pkg::ROW0_RESET, smt_pkg::ROW1_RESET, smt_pkg::ROW2_RESET,
                       32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000);
        send_vector(rand_vector(100));
        send_vector(rand_vector(100));
        send_vector(rand_vector(0));
    endtask

    // Several random transforms, each with a long stream of mostly plausible vectors.
    task automatic test_random_transforms();
        int phase;
        int n;
        for (phase = 0; phase < 6; phase++)
        begin
            load_transform(rand_rot_row(phase % 3), rand_rot_row(phase % 3),
                           rand_rot_row(phase % 3), rand_component(60), rand_component(60),
                           rand_component(60));
            for (n = 0; n < 250; n++)
                send_vector(rand_vector(70));
        end
    endtask

    // Back-to-back transfers with no idling on either side.
    task automatic test_full_rate();
        int n;
        drain_results();
        idle_en = 1'b0;
        load_transform(rand_rot_row(1), rand_rot_row(1), rand_rot_row(1),
                       rand_component(80), rand_component(80), rand_component(80));
        for (n = 0; n < 300; n++)
            send_vector(rand_vector(70));
    endtask

    // Main sequence.
    initial
    begin
        rot_row[0] = smt_pkg::ROW0_RESET;
        rot_row[1] = smt_pkg::ROW1_RESET;
        rot_row[2] = smt_pkg::ROW2_RESET;
        trans[0] = '0;
        trans[1] = '0;
        trans[2] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_identity();
        test_saturation();
        test_rounding_ties();
        test_random_transforms();
        test_full_rate();
        drain_results();
        if (mismatch_count == 0 && transformed_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
